### rtl/bipolar_hv_polarity_sequencer_macros.svh
// Assertion macros shared by the polarity sequencer RTL.
`ifndef BIPOLAR_HV_POLARITY_SEQUENCER_MACROS_SVH
`define BIPOLAR_HV_POLARITY_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define BHPS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define BHPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BHPS_ASSERT(label, clk, rstn, prop, msg)
`define BHPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/bhps_pkg.sv
// Types and constants of the bipolar high-voltage polarity sequencer.
package bhps_pkg;

    localparam int CFG_W      = 16;
    localparam int VOLT_W     = 16;
    localparam int PHASE_W    = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int IN_ITEM_W  = 20;
    localparam int OUT_ITEM_W = 9;
    localparam int REG_IDX_W  = 3;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_POS_START = 3'd0;
    localparam logic [PHASE_W-1:0] PH_POS_ON    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_POS_WAIT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_NEG_START = 3'd3;
    localparam logic [PHASE_W-1:0] PH_NEG_ON    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_NEG_WAIT  = 3'd5;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_SWITCH_DELAY = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POS_CHARGE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NEG_CHARGE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POS_ON       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NEG_ON       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_THRESH  = 3'd5;

    // Input word, last field in the lowest bit
    typedef struct packed {
        logic [VOLT_W-1:0] mean_voltage;
        logic              hold;
        logic              stop_request;
        logic              start_request;
        logic              ms_elapsed;
    } in_item_t;

    // Result word, last field in the lowest bit
    typedef struct packed {
        logic               stopping_now;
        logic               running;
        logic [PHASE_W-1:0] phase_now;
        logic               bridge_neg_run;
        logic               bridge_pos_run;
        logic               gate_neg_on;
        logic               gate_pos_on;
    } out_item_t;

endpackage

### rtl/bipolar_hv_polarity_sequencer.sv
// Top level of the bipolar high-voltage polarity sequencer.
//
// Steps a bipolar HV output through positive start, positive on, positive
// wait, negative start, negative on and negative wait, driving gate and
// bridge enable levels. Each input word carries a millisecond tick, start,
// stop and hold requests and the mean voltage reading; each one produces
// exactly one result word with the enable levels, the phase and the run and
// stop flags as they stand after that word. The block takes one word per
// clock while the result slot is not held by m_tready: a word is captured
// in an input register, and once the result slot is free a single pass of
// next-state logic (one CMP_W-wide compare against a register, a saturating
// increment and the phase selection) updates the sequencer state. That state
// register doubles as the result register, so a result reaches m_tdata
// through the input register and then the state register, and a new word
// may enter while a result waits for m_tready. TIME_BITS sets the width of
// the saturating millisecond counter. Registers are written over the
// APB-style port at byte address 4*index and must only change while the block is idle.
`include "bipolar_hv_polarity_sequencer_macros.svh"

module bipolar_hv_polarity_sequencer #(
    parameter int TIME_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] ms_elapsed, [1] start_request, [2] stop_request, [3] hold,
    // [19:4] mean_voltage, [23:20] zero
    input  logic [bhps_pkg::S_TDATA_W-1:0]     s_tdata,
    // Result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] gate_pos_on, [1] gate_neg_on, [2] bridge_pos_run, [3] bridge_neg_run,
    // [6:4] phase_now, [7] running, [8] stopping_now, [15:9] zero
    output logic [bhps_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bhps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bhps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bhps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    // Compare width covers both the counter and the 16-bit registers.
    localparam int CMP_W = (TIME_BITS > bhps_pkg::CFG_W) ? TIME_BITS : bhps_pkg::CFG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bhps_pkg::CFG_W-1:0]     switch_delay_reg;
    logic [bhps_pkg::CFG_W-1:0]     pos_charge_reg;
    logic [bhps_pkg::CFG_W-1:0]     neg_charge_reg;
    logic [bhps_pkg::CFG_W-1:0]     pos_on_reg;
    logic [bhps_pkg::CFG_W-1:0]     neg_on_reg;
    logic [bhps_pkg::CFG_W-1:0]     volt_thresh_reg;
    logic                           cfg_wr;
    logic [bhps_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [bhps_pkg::CFG_W-1:0]     cfg_rd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[bhps_pkg::APB_ADDR_W-1:2];

    // Write at the access cycle; addresses past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_delay_reg <= '0;
            pos_charge_reg   <= '0;
            neg_charge_reg   <= '0;
            pos_on_reg       <= '0;
            neg_on_reg       <= '0;
            volt_thresh_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bhps_pkg::REG_SWITCH_DELAY: switch_delay_reg <= pwdata[bhps_pkg::CFG_W-1:0];
                bhps_pkg::REG_POS_CHARGE:   pos_charge_reg   <= pwdata[bhps_pkg::CFG_W-1:0];
                bhps_pkg::REG_NEG_CHARGE:   neg_charge_reg   <= pwdata[bhps_pkg::CFG_W-1:0];
                bhps_pkg::REG_POS_ON:       pos_on_reg       <= pwdata[bhps_pkg::CFG_W-1:0];
                bhps_pkg::REG_NEG_ON:       neg_on_reg       <= pwdata[bhps_pkg::CFG_W-1:0];
                bhps_pkg::REG_VOLT_THRESH:  volt_thresh_reg  <= pwdata[bhps_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bhps_pkg::REG_SWITCH_DELAY: cfg_rd = switch_delay_reg;
            bhps_pkg::REG_POS_CHARGE:   cfg_rd = pos_charge_reg;
            bhps_pkg::REG_NEG_CHARGE:   cfg_rd = neg_charge_reg;
            bhps_pkg::REG_POS_ON:       cfg_rd = pos_on_reg;
            bhps_pkg::REG_NEG_ON:       cfg_rd = neg_on_reg;
            bhps_pkg::REG_VOLT_THRESH:  cfg_rd = volt_thresh_reg;
            default:                    cfg_rd = '0;
        endcase
    end

    assign prdata = bhps_pkg::APB_DATA_W'(cfg_rd);

    // ------------------------------------------------------------------
    // Handshake: input register feeding the state/result register
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    logic                in_valid_next;
    bhps_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;
    logic                item_move;

    // Result slot is free when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || m_tready;
    // Advance the captured word into the state when the result slot frees.
    assign item_move = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (item_move) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= bhps_pkg::in_item_t'(s_tdata[bhps_pkg::IN_ITEM_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state (also the result register)
    // ------------------------------------------------------------------
    logic [bhps_pkg::PHASE_W-1:0] phase_reg;
    logic [bhps_pkg::PHASE_W-1:0] phase_next;
    logic [TIME_BITS-1:0]         elapsed_reg;
    logic [TIME_BITS-1:0]         elapsed_next;
    logic                         running_reg;
    logic                         running_next;
    logic                         stopping_reg;
    logic                         stopping_next;
    logic                         gate_pos_reg;
    logic                         gate_pos_next;
    logic                         gate_neg_reg;
    logic                         gate_neg_next;
    logic                         bridge_pos_reg;
    logic                         bridge_pos_next;
    logic                         bridge_neg_reg;
    logic                         bridge_neg_next;
    logic [CMP_W-1:0]             elapsed_cmp;

    // Order per word: start, stop, tick, then phase evaluation.
    always_comb begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        running_next    = running_reg;
        stopping_next   = stopping_reg;
        gate_pos_next   = gate_pos_reg;
        gate_neg_next   = gate_neg_reg;
        bridge_pos_next = bridge_pos_reg;
        bridge_neg_next = bridge_neg_reg;
        elapsed_cmp     = CMP_W'(elapsed_reg);

        if (item_move) begin
            // Start restarts the loop from positive start, even while running.
            if (in_item_reg.start_request) begin
                running_next    = 1'b1;
                stopping_next   = 1'b0;
                phase_next      = bhps_pkg::PH_POS_START;
                elapsed_next    = '0;
                gate_pos_next   = 1'b0;
                gate_neg_next   = 1'b0;
                bridge_pos_next = 1'b0;
                bridge_neg_next = 1'b0;
            end
            if (in_item_reg.stop_request) begin
                stopping_next = 1'b1;
            end
            // Saturating millisecond count, advancing even when idle or held.
            if (in_item_reg.ms_elapsed && (elapsed_next != TIME_MAX)) begin
                elapsed_next = elapsed_next + 1'b1;
            end
            elapsed_cmp = CMP_W'(elapsed_next);

            if (running_next && !in_item_reg.hold) begin
                unique case (phase_next)
                    bhps_pkg::PH_POS_START: begin
                        if (stopping_next) begin
                            // Complete the stop; the phase keeps its code.
                            if (!bridge_pos_next) begin
                                gate_pos_next = 1'b0;
                                gate_neg_next = 1'b0;
                                running_next  = 1'b0;
                                stopping_next = 1'b0;
                                elapsed_next  = '0;
                            end
                        end else if (!gate_pos_next) begin
                            if (elapsed_cmp >= CMP_W'(switch_delay_reg)) begin
                                gate_pos_next = 1'b1;
                                elapsed_next  = '0;
                            end
                        end else if (elapsed_cmp >= CMP_W'(pos_charge_reg)) begin
                            bridge_pos_next = 1'b1;
                            phase_next      = bhps_pkg::PH_POS_ON;
                            elapsed_next    = '0;
                        end
                    end
                    bhps_pkg::PH_POS_ON: begin
                        // Leave on time or stop; counter keeps running.
                        if ((elapsed_cmp >= CMP_W'(pos_on_reg)) || stopping_next) begin
                            bridge_pos_next = 1'b0;
                            phase_next      = bhps_pkg::PH_POS_WAIT;
                        end
                    end
                    bhps_pkg::PH_POS_WAIT: begin
                        if (in_item_reg.mean_voltage <= volt_thresh_reg) begin
                            gate_pos_next = 1'b0;
                            elapsed_next  = '0;
                            phase_next    = bhps_pkg::PH_NEG_START;
                        end
                    end
                    bhps_pkg::PH_NEG_START: begin
                        if (stopping_next) begin
                            if (!bridge_neg_next) begin
                                gate_pos_next = 1'b0;
                                gate_neg_next = 1'b0;
                                running_next  = 1'b0;
                                stopping_next = 1'b0;
                                elapsed_next  = '0;
                            end
                        end else if (!gate_neg_next) begin
                            if (elapsed_cmp >= CMP_W'(switch_delay_reg)) begin
                                gate_neg_next = 1'b1;
                                elapsed_next  = '0;
                            end
                        end else if (elapsed_cmp >= CMP_W'(neg_charge_reg)) begin
                            bridge_neg_next = 1'b1;
                            phase_next      = bhps_pkg::PH_NEG_ON;
                            elapsed_next    = '0;
                        end
                    end
                    bhps_pkg::PH_NEG_ON: begin
                        if ((elapsed_cmp >= CMP_W'(neg_on_reg)) || stopping_next) begin
                            bridge_neg_next = 1'b0;
                            phase_next      = bhps_pkg::PH_NEG_WAIT;
                        end
                    end
                    bhps_pkg::PH_NEG_WAIT: begin
                        if (in_item_reg.mean_voltage <= volt_thresh_reg) begin
                            gate_neg_next = 1'b0;
                            elapsed_next  = '0;
                            phase_next    = bhps_pkg::PH_POS_START;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= bhps_pkg::PH_POS_START;
            elapsed_reg    <= '0;
            running_reg    <= 1'b0;
            stopping_reg   <= 1'b0;
            gate_pos_reg   <= 1'b0;
            gate_neg_reg   <= 1'b0;
            bridge_pos_reg <= 1'b0;
            bridge_neg_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            running_reg    <= running_next;
            stopping_reg   <= stopping_next;
            gate_pos_reg   <= gate_pos_next;
            gate_neg_reg   <= gate_neg_next;
            bridge_pos_reg <= bridge_pos_next;
            bridge_neg_reg <= bridge_neg_next;
        end
    end

    // ------------------------------------------------------------------
    // Result word: state only changes when a word advances, so it holds
    // steady while a result waits for m_tready.
    // ------------------------------------------------------------------
    bhps_pkg::out_item_t out_item;

    always_comb begin
        out_item.gate_pos_on    = gate_pos_reg;
        out_item.gate_neg_on    = gate_neg_reg;
        out_item.bridge_pos_run = bridge_pos_reg;
        out_item.bridge_neg_run = bridge_neg_reg;
        out_item.phase_now      = phase_reg;
        out_item.running        = running_reg;
        out_item.stopping_now   = stopping_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bhps_pkg::M_TDATA_W'(out_item);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BHPS_ASSERT(a_gates_exclusive, aclk, aresetn, !(gate_pos_reg && gate_neg_reg), "both gates on")
    `BHPS_ASSERT(a_bridge_needs_gate, aclk, aresetn, (!bridge_pos_reg || gate_pos_reg) && (!bridge_neg_reg || gate_neg_reg), "bridge runs with gate off")
    `BHPS_ASSERT_NEXT(a_state_frozen, aclk, aresetn, !item_move, $stable(phase_reg) && $stable(elapsed_reg) && $stable(running_reg), "state moved without a word")
    `BHPS_ASSERT_NEXT(a_result_follows, aclk, aresetn, item_move, m_tvalid, "advanced word gave no result")

endmodule

### test/tb.sv
// Self-checking testbench for the bipolar high-voltage polarity sequencer.
`timescale 1ns / 1ps

module tb;

    localparam int          TIME_BITS   = 16;
    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int          HELD_TICKS  = 63;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    // [0] ms_elapsed, [1] start_request, [2] stop_request, [3] hold,
    // [19:4] mean_voltage, [23:20] zero
    logic [bhps_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [0] gate_pos_on, [1] gate_neg_on, [2] bridge_pos_run, [3] bridge_neg_run,
    // [6:4] phase_now, [7] running, [8] stopping_now, [15:9] zero
    logic [bhps_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bhps_pkg::APB_ADDR_W-1:0] paddr;
    logic [bhps_pkg::APB_DATA_W-1:0] pwdata;
    logic [bhps_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    bipolar_hv_polarity_sequencer #(
        .TIME_BITS (TIME_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sequencer mirror: registers, phase, counter and enable flags as the
    // block should hold them after every accepted word.
    // ------------------------------------------------------------------
    logic [bhps_pkg::CFG_W-1:0]   cfg_shadow [0:5];
    logic [bhps_pkg::PHASE_W-1:0] seq_phase  = bhps_pkg::PH_POS_START;
    logic [TIME_BITS-1:0]         ms_count   = '0;
    logic                         run_flag   = 1'b0;
    logic                         stop_flag  = 1'b0;
    logic                         gate_pos   = 1'b0;
    logic                         gate_neg   = 1'b0;
    logic                         bridge_pos = 1'b0;
    logic                         bridge_neg = 1'b0;

    bhps_pkg::out_item_t pending_results [$];
    int        mismatch_count  = 0;
    int        words_sent      = 0;
    int        settings_used   = 0;
    int        phase_hits [0:7];
    int unsigned cycle_count   = 0;
    bit        idle_on         = 1'b1;

    // Start phase of one polarity: dead time, gate on, charge time, bridge on.
    // A pending stop completes here as long as the bridge is off.
    function automatic void start_phase_step(input bit pos);
        logic gate_now;
        logic bridge_now;
        logic [bhps_pkg::CFG_W-1:0] charge;
        gate_now   = pos ? gate_pos : gate_neg;
        bridge_now = pos ? bridge_pos : bridge_neg;
        charge     = pos ? cfg_shadow[bhps_pkg::REG_POS_CHARGE]
                         : cfg_shadow[bhps_pkg::REG_NEG_CHARGE];
        if (stop_flag) begin
            if (!bridge_now) begin
                gate_pos  = 1'b0;
                gate_neg  = 1'b0;
                run_flag  = 1'b0;
                stop_flag = 1'b0;
                ms_count  = '0;
            end
        end else if (!gate_now) begin
            if (ms_count >= cfg_shadow[bhps_pkg::REG_SWITCH_DELAY]) begin
                if (pos) gate_pos = 1'b1;
                else gate_neg = 1'b1;
                ms_count = '0;
            end
        end else if (ms_count >= charge) begin
            if (pos) begin
                bridge_pos = 1'b1;
                seq_phase  = bhps_pkg::PH_POS_ON;
            end else begin
                bridge_neg = 1'b1;
                seq_phase  = bhps_pkg::PH_NEG_ON;
            end
            ms_count = '0;
        end
    endfunction

    // Apply one word to the mirror and return the result word it must cause.
    function automatic bhps_pkg::out_item_t sequencer_step(input bhps_pkg::in_item_t w);
        bhps_pkg::out_item_t r;
        if (w.start_request) begin
            run_flag   = 1'b1;
            stop_flag  = 1'b0;
            seq_phase  = bhps_pkg::PH_POS_START;
            ms_count   = '0;
            gate_pos   = 1'b0;
            gate_neg   = 1'b0;
            bridge_pos = 1'b0;
            bridge_neg = 1'b0;
        end
        if (w.stop_request) stop_flag = 1'b1;
        if (w.ms_elapsed && ms_count != '1) ms_count = ms_count + 1'b1;
        if (run_flag && !w.hold) begin
            case (seq_phase)
                bhps_pkg::PH_POS_START: start_phase_step(1'b1);
                bhps_pkg::PH_POS_ON: begin
                    if (ms_count >= cfg_shadow[bhps_pkg::REG_POS_ON] || stop_flag) begin
                        bridge_pos = 1'b0;
                        seq_phase  = bhps_pkg::PH_POS_WAIT;
                    end
                end
                bhps_pkg::PH_POS_WAIT: begin
                    if (w.mean_voltage <= cfg_shadow[bhps_pkg::REG_VOLT_THRESH]) begin
                        gate_pos  = 1'b0;
                        ms_count  = '0;
                        seq_phase = bhps_pkg::PH_NEG_START;
                    end
                end
                bhps_pkg::PH_NEG_START: start_phase_step(1'b0);
                bhps_pkg::PH_NEG_ON: begin
                    if (ms_count >= cfg_shadow[bhps_pkg::REG_NEG_ON] || stop_flag) begin
                        bridge_neg = 1'b0;
                        seq_phase  = bhps_pkg::PH_NEG_WAIT;
                    end
                end
                bhps_pkg::PH_NEG_WAIT: begin
                    if (w.mean_voltage <= cfg_shadow[bhps_pkg::REG_VOLT_THRESH]) begin
                        gate_neg  = 1'b0;
                        ms_count  = '0;
                        seq_phase = bhps_pkg::PH_POS_START;
                    end
                end
                default: ;
            endcase
        end
        r.gate_pos_on    = gate_pos;
        r.gate_neg_on    = gate_neg;
        r.bridge_pos_run = bridge_pos;
        r.bridge_neg_run = bridge_neg;
        r.phase_now      = seq_phase;
        r.running        = run_flag;
        r.stopping_now   = stop_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random, compare each accepted word with the
    // oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !(idle_on && $urandom_range(0, 99) < 7);
    end

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        bhps_pkg::out_item_t got;
        bhps_pkg::out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[bhps_pkg::OUT_ITEM_W-1:0];
            phase_hits[got.phase_now]++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
            end else begin
                want = pending_results.pop_front();
                compare_field("gate_pos_on", want.gate_pos_on, got.gate_pos_on);
                compare_field("gate_neg_on", want.gate_neg_on, got.gate_neg_on);
                compare_field("bridge_pos_run", want.bridge_pos_run, got.bridge_pos_run);
                compare_field("bridge_neg_run", want.bridge_neg_run, got.bridge_neg_run);
                compare_field("phase_now", want.phase_now, got.phase_now);
                compare_field("running", want.running, got.running);
                compare_field("stopping_now", want.stopping_now, got.stopping_now);
            end
        end
    end

    // Watchdog: end the run if the block stops moving words.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one word, idling at random first; record its expected result
    // at the edge where it is taken.
    task automatic send_word(input bhps_pkg::in_item_t w);
        while (idle_on && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bhps_pkg::S_TDATA_W-bhps_pkg::IN_ITEM_W){1'b0}}, w};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(sequencer_step(w));
        words_sent++;
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Two-phase register write; the register takes the value at the access edge.
    // Release the bus before the next write.
    task automatic write_reg(input logic [bhps_pkg::REG_IDX_W-1:0] idx,
                             input logic [bhps_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(bhps_pkg::APB_DATA_W-bhps_pkg::CFG_W){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        cfg_shadow[idx] = value;
    endtask

    task automatic write_all_regs(input logic [bhps_pkg::CFG_W-1:0] sw,
                                  input logic [bhps_pkg::CFG_W-1:0] pc,
                                  input logic [bhps_pkg::CFG_W-1:0] nc,
                                  input logic [bhps_pkg::CFG_W-1:0] po,
                                  input logic [bhps_pkg::CFG_W-1:0] no,
                                  input logic [bhps_pkg::CFG_W-1:0] th);
        wait_results_done();
        write_reg(bhps_pkg::REG_SWITCH_DELAY, sw);
        write_reg(bhps_pkg::REG_POS_CHARGE, pc);
        write_reg(bhps_pkg::REG_NEG_CHARGE, nc);
        write_reg(bhps_pkg::REG_POS_ON, po);
        write_reg(bhps_pkg::REG_NEG_ON, no);
        write_reg(bhps_pkg::REG_VOLT_THRESH, th);
        settings_used++;
    endtask

    function automatic bhps_pkg::in_item_t make_word(input bit tick, input bit start,
                                                     input bit stop, input bit hold,
                                                     input logic [bhps_pkg::VOLT_W-1:0] mean);
        bhps_pkg::in_item_t w;
        w.ms_elapsed    = tick;
        w.start_request = start;
        w.stop_request  = stop;
        w.hold          = hold;
        w.mean_voltage  = mean;
        return w;
    endfunction

    // Mostly well-formed traffic: ticks, a restart when idle, rare stops and
    // holds, readings clustered around the threshold; some pure noise.
    function automatic bhps_pkg::in_item_t random_word();
        logic [bhps_pkg::IN_ITEM_W-1:0] raw;
        bhps_pkg::in_item_t w;
        int th;
        int pick;
        raw = $urandom;
        w   = raw;
        if ($urandom_range(0, 99) < 10) return w;
        th = cfg_shadow[bhps_pkg::REG_VOLT_THRESH];
        w.ms_elapsed    = $urandom_range(0, 99) < 70;
        w.start_request = run_flag ? ($urandom_range(0, 199) == 0)
                                   : ($urandom_range(0, 99) < 15);
        w.stop_request  = $urandom_range(0, 99) < 3;
        w.hold          = $urandom_range(0, 99) < 6;
        pick = $urandom_range(0, 99);
        if (pick < 40) w.mean_voltage = $urandom_range(0, th);
        else if (pick < 80) w.mean_voltage = (th == 65535) ? 16'hFFFF :
            $urandom_range(th + 1, (th + 60 > 65535) ? 65535 : th + 60);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: every delay zero, so one word per step walks the phases.
    task automatic test_reset_config();
        send_word(make_word(1, 0, 0, 0, 16'h0000));
        send_word(make_word(0, 1, 0, 0, 16'hFFFF));
        send_word(make_word(0, 0, 0, 0, 16'hFFFF));
        send_word(make_word(0, 0, 0, 0, 16'hFFFF));
        send_word(make_word(0, 0, 0, 0, 16'h0001));
        send_word(make_word(1, 0, 0, 0, 16'h0000));
    endtask

    // Walk both polarities by hand: stop while disabled, hold, on-time
    // expiry, wait above and at threshold, stop in an on phase, stop in a
    // start phase, start with stop, restart while running.
    task automatic test_directed_sequence();
        write_all_regs(16'd1, 16'd1, 16'd2, 16'd2, 16'd1, 16'd100);
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(0, 0, 1, 0, 16'd0));
        send_word(make_word(0, 1, 0, 0, 16'd500));
        send_word(make_word(1, 0, 0, 0, 16'd500));
        send_word(make_word(1, 0, 0, 1, 16'd500));
        send_word(make_word(1, 0, 0, 0, 16'd500));
        send_word(make_word(1, 0, 0, 0, 16'd500));
        send_word(make_word(1, 0, 0, 0, 16'd500));
        send_word(make_word(0, 0, 0, 0, 16'd101));
        send_word(make_word(0, 0, 0, 0, 16'd100));
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(0, 0, 1, 0, 16'd0));
        send_word(make_word(0, 0, 0, 0, 16'hFFFF));
        send_word(make_word(0, 0, 0, 0, 16'd0));
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(0, 1, 1, 0, 16'd0));
        send_word(make_word(0, 1, 0, 0, 16'd0));
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(1, 1, 0, 0, 16'd0));
        send_word(make_word(1, 0, 0, 1, 16'hFFFF));
        send_word(make_word(0, 0, 1, 0, 16'd0));
    endtask

    // Random traffic under several register settings, extremes included;
    // the second setting runs with no idling on either side.
    task automatic test_random_settings();
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: write_all_regs($urandom_range(0, 4), $urandom_range(0, 4),
                                  $urandom_range(0, 4), $urandom_range(0, 4),
                                  $urandom_range(0, 4), $urandom_range(1000, 50000));
                1: write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
                2: write_all_regs($urandom_range(0, 3), $urandom_range(0, 3),
                                  $urandom_range(0, 3), $urandom_range(0, 3),
                                  $urandom_range(0, 3), 16'd0);
                3: write_all_regs(16'd0, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF,
                                  $urandom_range(0, 65535));
                default: write_all_regs($urandom_range(0, 8), $urandom_range(0, 8),
                                        $urandom_range(0, 8), $urandom_range(0, 8),
                                        $urandom_range(0, 8), $urandom);
            endcase
            idle_on = (k != 1);
            for (int n = 0; n < 130; n++) send_word(random_word());
            idle_on = 1'b1;
        end
    endtask

    // Held ticks keep counting: the gate may only switch on at the first
    // unheld tick if every held tick was counted.
    task automatic test_held_ticks();
        bhps_pkg::in_item_t w;
        write_all_regs(16'd64, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_word(make_word(0, 1, 0, 0, 16'd0));
        for (int n = 0; n < HELD_TICKS; n++) begin
            w = make_word(1, 0, 0, 1, 16'd0);
            w.mean_voltage = $urandom;
            send_word(w);
        end
        send_word(make_word(1, 0, 0, 0, 16'd0));
        send_word(make_word(0, 0, 1, 0, 16'd0));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 6; i++) cfg_shadow[i] = '0;
        for (int i = 0; i < 8; i++) phase_hits[i] = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_directed_sequence();
        test_random_settings();
        test_held_ticks();

        // Drain, then let the pipeline settle.
        wait_results_done();
        repeat (4) @(posedge aclk);

        $display("Sent %0d input words across %0d register settings, held ticks included.",
                 words_sent, settings_used);
        $display("Results by phase: pos start %0d, pos on %0d, pos wait %0d,",
                 phase_hits[0], phase_hits[1], phase_hits[2]);
        $display("                  neg start %0d, neg on %0d, neg wait %0d",
                 phase_hits[3], phase_hits[4], phase_hits[5]);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
